### hdl/tst_pkg.sv
package tst_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        CMD_SET_DEACT = 3'd0,
        CMD_GET_DEACT = 3'd1,
        CMD_GET_TYPE  = 3'd2,
        CMD_SET_TYPE  = 3'd3,
        CMD_ADD_OFF   = 3'd4,
        CMD_GET_OFF   = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam int          REG_W        = 3;
    localparam logic [REG_W-1:0] REG_MISS_TYPE = 3'd0;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] deact;
        logic [1:0]  ttype;
        logic [31:0] offset;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

### hdl/tst_store.sv
module tst_store (
    input  logic              i_clk,
    input  tst_pkg::t_mem_req i_req,
    output tst_pkg::t_entry   o_rd_data
);
    import tst_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/tst_seq.sv
module tst_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_cmd,
    input  logic [31:0]       i_thread_id,
    input  logic [31:0]       i_write_value,
    input  logic [1:0]        i_type_code,
    input  logic [1:0]        i_miss_type,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [31:0]       o_read_value,
    output tst_pkg::t_mem_req o_req,
    input  tst_pkg::t_entry   i_rd_data
);
    import tst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_cmd;
    logic [31:0]      r_key;
    logic [31:0]      r_wval;
    logic [1:0]       r_tcode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pidx;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_entry           r_ent, n_ent;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_rval, n_rval;

    logic   issue, hit, out_free, accept;
    t_entry wr_ent;
    logic   wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign issue    = (r_state == S_SCAN) && (r_idx < r_count);
    // the single key comparator, fed one stored key per cycle
    assign hit      = r_pend && (i_rd_data.key == r_key);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_found     = r_found;
        n_slot      = r_slot;
        n_ent       = r_ent;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_rval      = r_rval;
        wr_en       = 1'b0;
        wr_addr     = r_slot;
        wr_ent      = r_ent;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = issue;
                n_idx  = r_idx + CNT_W'(issue);
                if (hit) begin
                    n_found = 1'b1;
                    n_slot  = r_pidx;
                    n_ent   = i_rd_data;
                    n_state = S_EXEC;
                end else if (!issue) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_status    = ST_OK;
                    n_rval      = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    wr_ent.key  = r_key;
                    case (r_cmd)
                        CMD_SET_DEACT: begin
                            wr_ent.deact = r_wval;
                            if (r_found) begin
                                wr_en = 1'b1;
                            end else if (r_count < CNT_W'(ENTRIES)) begin
                                // insert into the lowest free slot
                                wr_en         = 1'b1;
                                wr_addr       = r_count[IDX_W-1:0];
                                wr_ent.ttype  = i_miss_type;
                                wr_ent.offset = '0;
                                n_count       = r_count + 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_GET_DEACT: begin
                            if (r_found) begin
                                n_rval = r_ent.deact;
                            end else begin
                                n_status = ST_MISS;
                                n_rval   = ALL_ONES;
                            end
                        end
                        CMD_GET_TYPE: begin
                            if (r_found) begin
                                n_rval = {30'd0, r_ent.ttype};
                            end else begin
                                n_status = ST_MISS;
                                n_rval   = {30'd0, i_miss_type};
                            end
                        end
                        CMD_SET_TYPE: begin
                            if (r_found) begin
                                wr_en        = 1'b1;
                                wr_ent.ttype = r_tcode;
                            end else begin
                                n_status = ST_MISS;
                            end
                        end
                        CMD_ADD_OFF: begin
                            if (r_found) begin
                                wr_en         = 1'b1;
                                wr_ent.offset = r_ent.offset + r_wval;
                            end else begin
                                n_status = ST_MISS;
                            end
                        end
                        CMD_GET_OFF: begin
                            if (r_found) begin
                                n_rval = r_ent.offset;
                            end else begin
                                n_status = ST_MISS;
                                n_rval   = ALL_ONES;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_key   <= i_thread_id;
            r_wval  <= i_write_value;
            r_tcode <= i_type_code;
        end
        r_pidx   <= r_idx[IDX_W-1:0];
        r_slot   <= n_slot;
        r_ent    <= n_ent;
        r_status <= n_status;
        r_rval   <= n_rval;
    end

    assign o_req.rd_addr = r_idx[IDX_W-1:0];
    assign o_req.wr_en   = wr_en;
    assign o_req.wr_addr = wr_addr;
    assign o_req.wr_data = wr_ent;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rval;

endmodule

### hdl/thread_state_table.sv
// A request is accepted, then scanned over the N records held (N = 0..16), then executed into the output register.
// The key scan reads one stored record per cycle through a single comparator and stops early on a hit;
// a miss scans all N records before its result is produced.
// A new request is taken while the previous result waits in the output register.
// Synchronous active-low reset empties the table and sets the miss type code to 0.
module thread_state_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] thread_id, [63:32] write_value, [65:64] type_code, [71:66] zero
    input  logic [71:0] i_s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] read_value
    output logic [31:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [tst_pkg::REG_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tst_pkg::*;

    logic [1:0] r_miss_type;
    t_mem_req   req;
    t_entry     rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_type <= '0;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr == REG_MISS_TYPE)) begin
            r_miss_type <= i_pwdata[1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == REG_MISS_TYPE) ? {30'd0, r_miss_type} : 32'd0;

    tst_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_cmd         (i_s_axis_tuser),
        .i_thread_id   (i_s_axis_tdata[31:0]),
        .i_write_value (i_s_axis_tdata[63:32]),
        .i_type_code   (i_s_axis_tdata[65:64]),
        .i_miss_type   (r_miss_type),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (o_m_axis_tuser),
        .o_read_value  (o_m_axis_tdata),
        .o_req         (req),
        .i_rd_data     (rd_data)
    );

    tst_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

endmodule

### hdl/tst_checker.sv
module tst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import tst_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready while scanning");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_MISS ||
            o_m_axis_tuser == ST_FULL)
        else $error("bad status code");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL |-> o_m_axis_tdata == 32'd0)
        else $error("full status with nonzero data");

endmodule

bind thread_state_table tst_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
